[hw/rtl/pwmc_pkg.sv]
// pwmc_pkg: types and constants for the 16-channel PWM LED controller
// used by pwmc_chan and pwm_controller_16ch; depends on nothing else
package pwmc_pkg;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // byte position within one channel's register group
    typedef enum logic [1:0] {
        BYTE_ON_L  = 2'd0,
        BYTE_ON_H  = 2'd1,
        BYTE_OFF_L = 2'd2,
        BYTE_OFF_H = 2'd3
    } byte_sel_t;

    // register map
    localparam logic [7:0] REG_MODE     = 8'h00;
    localparam logic [7:0] REG_PRESCALE = 8'hFE;
    localparam logic [7:0] REG_CH_BASE  = 8'h06;

    // reset values and limits
    localparam logic [7:0] MODE_RESET     = 8'h11;
    localparam logic [7:0] PRESCALE_RESET = 8'd30;
    localparam logic [7:0] PRESCALE_MIN   = 8'd3;
    localparam int         SLEEP_BIT      = 4;
    localparam int         FULL_BIT       = 4;
    localparam int         STORED_CNT_BITS = 12;
    localparam int         MAX_CHANNELS   = 16;

    typedef struct packed {
        func_t       func;
        logic [7:0]  reg_addr;
        logic [7:0]  wdata;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [15:0] pwm_out;
    } out_item_t;

    // control from the top level to one channel
    typedef struct packed {
        logic      fire;
        logic      wr_en;
        byte_sel_t sel;
        logic      cnt_adv;
    } chan_ctrl_t;

endpackage

[hw/rtl/pwm_controller_16ch.sv]
// pwm_controller_16ch: top level of the 16-channel 12-bit PWM LED controller
// depends on pwmc_pkg and pwmc_chan
//
// Each item is a register write, a register read or one oscillator tick, and
// each gives exactly one result: the byte read (zero otherwise) and the channel
// levels after the item. An item is registered on entry and processed from
// there into the result register, so one item is taken every cycle when the
// output does not stall. The entry register also holds one item while a
// finished result waits to be taken.
// Registers: mode at 0x00 (bit 4 sleep), prescale at 0xFE (written only while
// asleep, values below 3 act as 3), and four bytes per channel from 0x06.
module pwm_controller_16ch #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pwmc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output pwmc_pkg::out_item_t out_item
);

    logic                s1_valid_reg;
    pwmc_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg;
    pwmc_pkg::out_item_t out_item_reg;
    pwmc_pkg::out_item_t out_next;

    logic [7:0]            mode_reg, mode_next;
    logic [7:0]            prescale_reg, prescale_next;
    logic [7:0]            pcount_reg, pcount_next;
    logic [COUNT_BITS-1:0] pwm_count_reg, pwm_count_next;

    logic       fire;
    logic       is_write, is_read, is_tick;
    logic       awake;
    logic [7:0] eff_prescale;
    logic       cnt_adv;
    logic [7:0] ch_off;
    logic       chan_hit;
    logic [CHANNELS-1:0] ch_sel;
    logic [CHANNELS-1:0] lvl_next;
    logic [7:0]          ch_rdata [CHANNELS];
    logic [7:0]          rdata;
    logic [15:0]         pwm_bits;

    // handshake: the entry stage empties whenever the result register can load
    assign fire      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !fire;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // function decode
    always_comb
    begin
        is_write = 1'b0;
        is_read  = 1'b0;
        is_tick  = 1'b0;
        unique case (s1_item_reg.func)
            pwmc_pkg::FUNC_WRITE: is_write = 1'b1;
            pwmc_pkg::FUNC_READ:  is_read  = 1'b1;
            pwmc_pkg::FUNC_TICK:  is_tick  = 1'b1;
            pwmc_pkg::FUNC_NOP:   ;
            default:              ;
        endcase
    end

    // channel window decode
    assign ch_off   = s1_item_reg.reg_addr - pwmc_pkg::REG_CH_BASE;
    assign chan_hit = (s1_item_reg.reg_addr >= pwmc_pkg::REG_CH_BASE)
                   && (ch_off < 8'(4 * CHANNELS));

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
            ch_sel[c] = chan_hit && (ch_off[5:2] == 4'(c));
    end

    // mode and prescale writes
    always_comb
    begin
        mode_next     = mode_reg;
        prescale_next = prescale_reg;
        if (is_write && (s1_item_reg.reg_addr == pwmc_pkg::REG_MODE))
            mode_next = s1_item_reg.wdata;
        if (is_write && (s1_item_reg.reg_addr == pwmc_pkg::REG_PRESCALE)
            && mode_reg[pwmc_pkg::SLEEP_BIT])
            prescale_next = s1_item_reg.wdata;
    end

    // prescaler and pwm counter
    assign awake        = !mode_reg[pwmc_pkg::SLEEP_BIT];
    assign eff_prescale = (prescale_reg < pwmc_pkg::PRESCALE_MIN) ?
                          pwmc_pkg::PRESCALE_MIN : prescale_reg;

    always_comb
    begin
        pcount_next    = pcount_reg;
        pwm_count_next = pwm_count_reg;
        cnt_adv        = 1'b0;
        if (is_tick && awake)
        begin
            if (pcount_reg >= eff_prescale)
            begin
                pcount_next    = '0;
                pwm_count_next = pwm_count_reg + COUNT_BITS'(1);
                cnt_adv        = 1'b1;
            end
            else
            begin
                pcount_next = pcount_reg + 8'd1;
            end
        end
    end

    // channel bank
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        pwmc_pkg::chan_ctrl_t ctrl;

        always_comb
        begin
            ctrl.fire    = fire;
            ctrl.wr_en   = fire && is_write && ch_sel[g];
            ctrl.sel     = pwmc_pkg::byte_sel_t'(ch_off[1:0]);
            ctrl.cnt_adv = fire && cnt_adv;
        end

        pwmc_chan #(
            .COUNT_BITS (COUNT_BITS)
        ) u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wdata      (s1_item_reg.wdata),
            .pwm_count  (pwm_count_next),
            .rdata      (ch_rdata[g]),
            .level_next (lvl_next[g])
        );
    end

    // read data select
    always_comb
    begin
        rdata = 8'h00;
        if (is_read)
        begin
            if (s1_item_reg.reg_addr == pwmc_pkg::REG_MODE)
                rdata = mode_reg;
            else if (s1_item_reg.reg_addr == pwmc_pkg::REG_PRESCALE)
                rdata = prescale_reg;
            else
            begin
                for (int c = 0; c < CHANNELS; c++)
                    rdata = rdata | (ch_rdata[c] & {8{ch_sel[c]}});
            end
        end
    end

    // result assembly, unused channel bits stay low
    always_comb
    begin
        pwm_bits = '0;
        for (int c = 0; c < CHANNELS; c++)
            pwm_bits[c] = lvl_next[c];
        out_next.rdata   = rdata;
        out_next.pwm_out = pwm_bits;
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= pwmc_pkg::MODE_RESET;
            prescale_reg  <= pwmc_pkg::PRESCALE_RESET;
            pcount_reg    <= '0;
            pwm_count_reg <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (fire)
            begin
                mode_reg      <= mode_next;
                prescale_reg  <= prescale_next;
                pcount_reg    <= pcount_next;
                pwm_count_reg <= pwm_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_item_reg <= in_item;
        if (fire)
            out_item_reg <= out_next;
    end

endmodule

[hw/rtl/pwmc_chan.sv]
// pwmc_chan: one PWM channel, its ON/OFF count registers, full flags and level
// depends on pwmc_pkg
module pwmc_chan #(
    parameter int COUNT_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pwmc_pkg::chan_ctrl_t  ctrl,
    input  logic [7:0]            wdata,
    input  logic [COUNT_BITS-1:0] pwm_count,
    output logic [7:0]            rdata,
    output logic                  level_next
);

    logic [pwmc_pkg::STORED_CNT_BITS-1:0] on_reg, on_next;
    logic [pwmc_pkg::STORED_CNT_BITS-1:0] off_reg, off_next;
    logic full_on_reg, full_on_next;
    logic full_off_reg, full_off_next;
    logic level_reg;

    // register byte writes
    always_comb
    begin
        on_next       = on_reg;
        off_next      = off_reg;
        full_on_next  = full_on_reg;
        full_off_next = full_off_reg;
        if (ctrl.wr_en)
        begin
            unique case (ctrl.sel)
                pwmc_pkg::BYTE_ON_L:  on_next[7:0]  = wdata;
                pwmc_pkg::BYTE_ON_H:
                begin
                    on_next[11:8] = wdata[3:0];
                    full_on_next  = wdata[pwmc_pkg::FULL_BIT];
                end
                pwmc_pkg::BYTE_OFF_L: off_next[7:0] = wdata;
                pwmc_pkg::BYTE_OFF_H:
                begin
                    off_next[11:8] = wdata[3:0];
                    full_off_next  = wdata[pwmc_pkg::FULL_BIT];
                end
                default: ;
            endcase
        end
    end

    // output level: full-off over full-on over off match over on match
    always_comb
    begin
        level_next = level_reg;
        if (full_off_next)
            level_next = 1'b0;
        else if (full_on_next)
            level_next = 1'b1;
        else if (ctrl.cnt_adv && (pwm_count == off_next[COUNT_BITS-1:0]))
            level_next = 1'b0;
        else if (ctrl.cnt_adv && (pwm_count == on_next[COUNT_BITS-1:0]))
            level_next = 1'b1;
    end

    // read back of the selected byte
    always_comb
    begin
        unique case (ctrl.sel)
            pwmc_pkg::BYTE_ON_L:  rdata = on_reg[7:0];
            pwmc_pkg::BYTE_ON_H:  rdata = {3'b000, full_on_reg, on_reg[11:8]};
            pwmc_pkg::BYTE_OFF_L: rdata = off_reg[7:0];
            pwmc_pkg::BYTE_OFF_H: rdata = {3'b000, full_off_reg, off_reg[11:8]};
            default:              rdata = 8'h00;
        endcase
    end

    // state update, once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg       <= '0;
            off_reg      <= '0;
            full_on_reg  <= 1'b0;
            full_off_reg <= 1'b0;
            level_reg    <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            on_reg       <= on_next;
            off_reg      <= off_next;
            full_on_reg  <= full_on_next;
            full_off_reg <= full_off_next;
            level_reg    <= level_next;
        end
    end

endmodule

[sim/pwm_controller_16ch_tb.sv]
// pwm_controller_16ch_tb: self-checking testbench for the 16-channel PWM LED controller
// predicts every result from its own model of registers, prescaler, counter and levels
// depends on pwmc_pkg and pwm_controller_16ch
module pwm_controller_16ch_tb;

    import pwmc_pkg::*;

    localparam int        CYCLE_LIMIT      = 400000;
    localparam int        SETTLE_CYCLES    = 20;
    localparam int        MAX_REPORTS      = 10;
    localparam int        RANDOM_ITEMS     = 540;
    localparam int        PRESSURE_ITEMS   = 50;
    localparam int        HOLD_CYCLES      = 60;
    localparam logic [7:0] HIGH_BYTE_MASK  = 8'h1F;
    localparam logic [7:0] ADDR_GAP        = 8'h05;
    localparam logic [7:0] ADDR_PAST_WINDOW = REG_CH_BASE + 8'd64;
    localparam logic [7:0] ADDR_TOP        = 8'hFF;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    // model of the device registers and counters
    logic [7:0]  reg_bytes [64];
    logic [7:0]  mode_byte;
    logic [7:0]  prescale_byte;
    logic [7:0]  tick_div;
    logic [11:0] pwm_counter;
    logic [15:0] level_bits;

    out_item_t expected_results [$];

    int send_gap_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int items_sent;
    int results_checked;
    int error_count;
    int cycle_count;

    pwm_controller_16ch u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // reset the model to the power-up state
    task automatic reset_levels_model();
        foreach (reg_bytes[i])
        begin
            reg_bytes[i] = 8'h00;
        end
        mode_byte     = MODE_RESET;
        prescale_byte = PRESCALE_RESET;
        tick_div      = 8'h00;
        pwm_counter   = 12'h000;
        level_bits    = 16'h0000;
    endtask

    // apply one item to the model and return the levels and byte it yields
    function automatic out_item_t pwm_predict(input in_item_t it);
        out_item_t   res;
        logic        advanced;
        logic        chan_hit;
        int          idx;
        logic [7:0]  eff;
        logic [7:0]  on_l, on_h, off_l, off_h;
        logic [11:0] on_cnt, off_cnt;
        res      = '0;
        advanced = 1'b0;
        idx      = int'(it.reg_addr) - int'(REG_CH_BASE);
        chan_hit = (idx >= 0) && (idx < 4 * MAX_CHANNELS);
        case (it.func)
            FUNC_WRITE:
            begin
                if (it.reg_addr == REG_MODE)
                    mode_byte = it.wdata;
                else if (it.reg_addr == REG_PRESCALE)
                begin
                    // prescale only taken while asleep
                    if (mode_byte[SLEEP_BIT])
                        prescale_byte = it.wdata;
                end
                else if (chan_hit)
                    reg_bytes[idx] = idx[0] ? (it.wdata & HIGH_BYTE_MASK) : it.wdata;
            end
            FUNC_READ:
            begin
                if (it.reg_addr == REG_MODE)
                    res.rdata = mode_byte;
                else if (it.reg_addr == REG_PRESCALE)
                    res.rdata = prescale_byte;
                else if (chan_hit)
                    res.rdata = reg_bytes[idx];
            end
            FUNC_TICK:
            begin
                // prescaler wraps at or above the effective prescale
                if (!mode_byte[SLEEP_BIT])
                begin
                    eff = (prescale_byte < PRESCALE_MIN) ? PRESCALE_MIN : prescale_byte;
                    if (tick_div >= eff)
                    begin
                        tick_div    = 8'h00;
                        pwm_counter = pwm_counter + 12'd1;
                        advanced    = 1'b1;
                    end
                    else
                        tick_div = tick_div + 8'd1;
                end
            end
            default: ;
        endcase
        // full-off beats full-on beats an off match beats an on match
        for (int ch = 0; ch < MAX_CHANNELS; ch++)
        begin
            on_l    = reg_bytes[4 * ch + int'(BYTE_ON_L)];
            on_h    = reg_bytes[4 * ch + int'(BYTE_ON_H)];
            off_l   = reg_bytes[4 * ch + int'(BYTE_OFF_L)];
            off_h   = reg_bytes[4 * ch + int'(BYTE_OFF_H)];
            on_cnt  = {on_h[3:0], on_l};
            off_cnt = {off_h[3:0], off_l};
            if (off_h[FULL_BIT])
                level_bits[ch] = 1'b0;
            else if (on_h[FULL_BIT])
                level_bits[ch] = 1'b1;
            else if (advanced && pwm_counter == off_cnt)
                level_bits[ch] = 1'b0;
            else if (advanced && pwm_counter == on_cnt)
                level_bits[ch] = 1'b1;
        end
        res.pwm_out = level_bits;
        return res;
    endfunction

    // result check first, then prediction for the item taken at this edge
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: rdata=%02h pwm_out=%04h",
                                 out_item.rdata, out_item.pwm_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.rdata !== want.rdata || out_item.pwm_out !== want.pwm_out)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: expected rdata=%02h pwm_out=%04h, got rdata=%02h pwm_out=%04h",
                                     want.rdata, want.pwm_out,
                                     out_item.rdata, out_item.pwm_out);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(pwm_predict(in_item));
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_results.size());
            $display("[pwm_controller_16ch] ERROR");
            $finish;
        end
    end

    function automatic in_item_t make_item(func_t f, logic [7:0] addr, logic [7:0] data);
        in_item_t it;
        it.func     = f;
        it.reg_addr = addr;
        it.wdata    = data;
        return it;
    endfunction

    function automatic logic [7:0] chan_addr(int ch, byte_sel_t sel);
        return REG_CH_BASE + 8'(4 * ch) + 8'(sel);
    endfunction

    // offer one item, with random gaps, until it is taken
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(logic [7:0] addr, logic [7:0] data);
        send_item(make_item(FUNC_WRITE, addr, data));
    endtask

    task automatic read_reg(logic [7:0] addr);
        send_item(make_item(FUNC_READ, addr, 8'($urandom_range(255))));
    endtask

    task automatic tick();
        send_item(make_item(FUNC_TICK, 8'($urandom_range(255)), 8'($urandom_range(255))));
    endtask

    // sender goes quiet until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // reset values, unmapped addresses, reserved bits, no-op
    task automatic test_register_map();
        read_reg(REG_MODE);
        read_reg(REG_PRESCALE);
        read_reg(ADDR_TOP);
        read_reg(ADDR_PAST_WINDOW);
        write_reg(ADDR_PAST_WINDOW, 8'hFF);
        write_reg(ADDR_GAP, 8'hFF);
        read_reg(ADDR_GAP);
        write_reg(chan_addr(0, BYTE_ON_L), 8'hFF);
        read_reg(chan_addr(0, BYTE_ON_L));
        write_reg(chan_addr(15, BYTE_OFF_H), 8'hFF);
        read_reg(chan_addr(15, BYTE_OFF_H));
        send_item(make_item(FUNC_NOP, 8'hFF, 8'hFF));
    endtask

    // full flags act at once while asleep, full-off wins
    task automatic test_full_flags();
        write_reg(chan_addr(15, BYTE_ON_H), 8'hF0);
        write_reg(chan_addr(0, BYTE_ON_H), 8'h10);
        write_reg(chan_addr(15, BYTE_OFF_H), 8'h00);
        tick();
    endtask

    // prescale below minimum, prescale ignored while awake, off beats on
    task automatic test_sleep_and_prescale();
        write_reg(REG_PRESCALE, 8'h00);
        read_reg(REG_PRESCALE);
        write_reg(chan_addr(0, BYTE_ON_H), 8'h00);
        write_reg(chan_addr(1, BYTE_ON_L), 8'h01);
        write_reg(chan_addr(1, BYTE_OFF_L), 8'h01);
        write_reg(REG_MODE, 8'hEF);
        write_reg(REG_PRESCALE, 8'h77);
        read_reg(REG_MODE);
        repeat (4)
            tick();
    endtask

    // one random item or short sequence, biased toward counts near the counter
    task automatic send_random_item();
        int          pick;
        int          ch;
        byte_sel_t   sel;
        logic [11:0] target;
        logic [7:0]  data;
        pick = $urandom_range(99);
        if (pick < 45)
            tick();
        else if (pick < 65)
        begin
            // channel byte aimed a little ahead of the counter
            ch     = $urandom_range(MAX_CHANNELS - 1);
            sel    = byte_sel_t'($urandom_range(3));
            target = pwm_counter + 12'($urandom_range(24, 1));
            if (sel == BYTE_ON_L || sel == BYTE_OFF_L)
                data = target[7:0];
            else
                data = {3'($urandom_range(7)), ($urandom_range(9) == 0), target[11:8]};
            write_reg(chan_addr(ch, sel), data);
        end
        else if (pick < 80)
        begin
            pick = $urandom_range(9);
            if (pick < 5)
                read_reg(chan_addr($urandom_range(MAX_CHANNELS - 1),
                                   byte_sel_t'($urandom_range(3))));
            else if (pick < 7)
                read_reg(pick[0] ? REG_MODE : REG_PRESCALE);
            else
                read_reg(8'($urandom_range(255)));
        end
        else if (pick < 85)
        begin
            // sleep, maybe tick, new prescale, wake
            data           = 8'($urandom_range(255));
            data[SLEEP_BIT] = 1'b1;
            write_reg(REG_MODE, data);
            repeat ($urandom_range(2))
                tick();
            if ($urandom_range(9) < 7)
                write_reg(REG_PRESCALE, 8'($urandom_range(6)));
            else
                write_reg(REG_PRESCALE, 8'($urandom_range(255)));
            data           = 8'($urandom_range(255));
            data[SLEEP_BIT] = 1'b0;
            write_reg(REG_MODE, data);
        end
        else if (pick < 88)
        begin
            data           = 8'($urandom_range(255));
            data[SLEEP_BIT] = 1'b0;
            write_reg(REG_MODE, data);
        end
        else
            send_item(make_item(func_t'($urandom_range(3)), 8'($urandom_range(255)),
                                8'($urandom_range(255))));
    endtask

    task automatic test_random_traffic(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_random_item();
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        int stop_at;
        stop_at      = items_sent + PRESSURE_ITEMS;
        hold_request = HOLD_CYCLES;
        while (items_sent < stop_at)
            send_random_item();
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_stall      = 1'b0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        items_sent     = 0;
        results_checked = 0;
        error_count    = 0;
        cycle_count    = 0;
        reset_levels_model();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 28;
        recv_stall_pct = 75;
        test_register_map();
        test_full_flags();
        test_sleep_and_prescale();
        wait_drained();

        test_random_traffic(RANDOM_ITEMS);
        send_gap_pct   = 75;
        recv_stall_pct = 28;
        test_random_traffic(RANDOM_ITEMS);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_traffic(RANDOM_ITEMS);
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0d results never arrived", expected_results.size());
        end

        $display("sent %0d items (register map, full flags, sleep, prescale, random traffic)",
                 items_sent);
        $display("checked %0d results under gaps, stalls and a long hold-off, %0d errors",
                 results_checked, error_count);
        if (error_count == 0)
            $display("[pwm_controller_16ch] OK");
        else
            $display("[pwm_controller_16ch] ERROR");
        $finish;
    end

endmodule
